>>> rtl/core/vbf_pkg.sv
// Package for the volume bilateral filter: payload structs, job and geometry types,
// field widths, register indexes and item codes. No dependencies.
package vbf_pkg;

  localparam int RADIUS_DEF      = 2;
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_DEPTH       = 4096;

  localparam int COORD_W    = 10;
  localparam int SLICE_W    = 12;
  localparam int DIM_W      = 11;
  localparam int DEPTH_W    = 13;
  localparam int AREA_W     = 21;
  localparam int LAG_W      = 24;
  localparam int SCALE_W    = 24;
  localparam int WEIGHT_W   = 16;
  localparam int TIDX_W     = 9;
  localparam int RANGE_N    = 256;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_VOL_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_DEPTH  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_SCALE = 4'd3;

  localparam logic [1:0] MODE_SAMPLE       = 2'd0;
  localparam logic [1:0] MODE_PAD          = 2'd1;
  localparam logic [1:0] MODE_LOAD_RANGE   = 2'd2;
  localparam logic [1:0] MODE_LOAD_SPATIAL = 2'd3;

  localparam logic [1:0] JOB_FILTER  = 2'd0;
  localparam logic [1:0] JOB_RANGE   = 2'd1;
  localparam logic [1:0] JOB_SPATIAL = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [15:0]         sample;
    logic [TIDX_W-1:0]   table_index;
    logic [WEIGHT_W-1:0] weight_value;
  } item_t;

  typedef struct packed {
    logic [15:0] filtered;
    logic [7:0]  out_column;
    logic [7:0]  out_row;
    logic [11:0] out_slice;
    logic        volume_done;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DEPTH_W-1:0] d;
    logic [AREA_W-1:0]  wh;
    logic [LAG_W-1:0]   lag;
    logic [SCALE_W-1:0] scale;
  } geom_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SLICE_W-1:0]  slice;
    logic                done;
    logic [TIDX_W-1:0]   table_index;
    logic [WEIGHT_W-1:0] weight;
  } job_t;

endpackage

>>> rtl/core/vbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/vbf_queue.sv
// Two-entry job queue between the front and back ends of the filter.
// Depends on vbf_pkg for job_t.
module vbf_queue import vbf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/vbf_divider.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module vbf_divider #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign trial    = {rem, dvd[NUM_W-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

>>> rtl/core/vbf_front.sv
// Front end: accepts items, stores samples in the slice ring, tracks the output
// position and queues filter and table-load jobs. Depends on vbf_pkg.
module vbf_front import vbf_pkg::*; #(
  parameter int RADIUS      = RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  restart,
  input  logic  geom_ok,
  input  geom_t geom,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  job_valid,
  input  logic  job_ready,
  output job_t  job,
  output logic  ring_we,
  output logic [$clog2((2*RADIUS+1)*MAX_WIDTH*MAX_HEIGHT)-1:0] ring_waddr,
  output logic [SAMPLE_BITS-1:0] ring_wdata,
  input  logic  back_idle,
  input  logic  queue_empty
);

  localparam int RING_N = (2*RADIUS+1) * MAX_WIDTH * MAX_HEIGHT;
  localparam int RA_W   = $clog2(RING_N);
  localparam int SB_EXT = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  logic [RA_W-1:0]    waddr;
  logic [RA_W-1:0]    fill;
  logic               primed;
  logic               drain;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [SLICE_W-1:0] slice;
  logic               is_load;
  logic               take;
  logic               emit;
  logic               col_end;
  logic               row_end;
  logic               slice_end;
  logic               last;
  logic [SB_EXT-1:0]  sample_ext;

  always_comb begin
    case (item.mode) inside
      MODE_LOAD_RANGE, MODE_LOAD_SPATIAL: is_load = 1'b1;
      default:                            is_load = 1'b0;
    endcase
  end

  assign item_ready = geom_ok && !drain && !restart && job_ready;
  assign take       = item_valid && item_ready;
  assign emit       = take && !is_load && primed;
  assign col_end    = (DIM_W'(col) + DIM_W'(1)) == geom.w;
  assign row_end    = (DIM_W'(row) + DIM_W'(1)) == geom.h;
  assign slice_end  = (DEPTH_W'(slice) + DEPTH_W'(1)) == geom.d;
  assign last       = col_end && row_end && slice_end;
  assign sample_ext = SB_EXT'(item.sample);

  assign ring_we    = take && !is_load;
  assign ring_waddr = waddr;
  assign ring_wdata = (item.mode == MODE_SAMPLE) ? sample_ext[SAMPLE_BITS-1:0] : '0;

  assign job_valid       = take && (is_load || primed);
  assign job.kind        = (item.mode == MODE_LOAD_RANGE)   ? JOB_RANGE :
                           (item.mode == MODE_LOAD_SPATIAL) ? JOB_SPATIAL : JOB_FILTER;
  assign job.col         = col;
  assign job.row         = row;
  assign job.slice       = slice;
  assign job.done        = last;
  assign job.table_index = item.table_index;
  assign job.weight      = item.weight_value;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      waddr  <= '0;
      fill   <= '0;
      primed <= 1'b0;
      drain  <= 1'b0;
      col    <= '0;
      row    <= '0;
      slice  <= '0;
    end else if (emit && last) begin
      waddr  <= '0;
      fill   <= '0;
      primed <= 1'b0;
      drain  <= 1'b1;
      col    <= '0;
      row    <= '0;
      slice  <= '0;
    end else begin
      if (drain && back_idle && queue_empty) begin
        drain <= 1'b0;
      end
      if (take && !is_load) begin
        waddr <= (waddr == RA_W'(RING_N - 1)) ? '0 : waddr + RA_W'(1);
        if (!primed) begin
          fill <= fill + RA_W'(1);
          if ((LAG_W'(fill) + LAG_W'(1)) == geom.lag) begin
            primed <= 1'b1;
          end
        end
      end
      if (emit) begin
        if (!col_end) begin
          col <= col + COORD_W'(1);
        end else begin
          col <= '0;
          if (!row_end) begin
            row <= row + COORD_W'(1);
          end else begin
            row   <= '0;
            slice <= slice + SLICE_W'(1);
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> (drain && !primed && waddr == '0))
    else $error("volume end did not restart the input side");

  assert property (@(posedge clk) disable iff (rst)
    (drain && !queue_empty) |-> !item_ready)
    else $error("item taken while the previous volume drains");

endmodule

>>> rtl/core/vbf_back.sv
// Back end: runs table loads and filter jobs; a neighbour pipeline over the ring
// and weight tables feeds the accumulators, then a shared divider. Depends on vbf_pkg.
module vbf_back import vbf_pkg::*; #(
  parameter int RADIUS      = RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    restart,
  input  geom_t   geom,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic [$clog2((2*RADIUS+1)*MAX_WIDTH*MAX_HEIGHT)-1:0] ring_raddr,
  input  logic [SAMPLE_BITS-1:0] ring_rdata,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  output logic    idle
);

  localparam int DIAM      = 2*RADIUS + 1;
  localparam int SPATIAL_N = DIAM * DIAM * DIAM;
  localparam int RING_N    = DIAM * MAX_WIDTH * MAX_HEIGHT;
  localparam int RA_W      = $clog2(RING_N);
  localparam int SP_AW     = $clog2(SPATIAL_N);
  localparam int DC_W      = $clog2(DIAM);
  localparam int CNT_B     = $clog2(SPATIAL_N + 1);
  localparam int NUM_W     = WEIGHT_W + SAMPLE_BITS + CNT_B;
  localparam int DEN_W     = WEIGHT_W + CNT_B;
  localparam int P_W       = SAMPLE_BITS + SCALE_W;
  localparam int X_W       = COORD_W + 2;
  localparam int Z_W       = SLICE_W + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CWAIT = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DWAIT = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  function automatic logic [RA_W-1:0] wrap_add(input logic [RA_W-1:0] a,
                                               input logic [RA_W-1:0] b);
    logic [RA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (RA_W+1)'(RING_N)) begin
      s = s - (RA_W+1)'(RING_N);
    end
    return s[RA_W-1:0];
  endfunction

  logic [2:0]             state;
  job_t                   cur;
  logic [RA_W-1:0]        ca;
  logic [SAMPLE_BITS-1:0] center;
  logic [SP_AW-1:0]       pos;
  logic [DC_W-1:0]        dx, dy, dz;
  logic signed [X_W-1:0]  nx, ny;
  logic signed [Z_W-1:0]  nz;
  logic [RA_W-1:0]        addr, row_base, plane_base;
  logic                   v1, v2, v3, v4, v5;
  logic [P_W-1:0]         p1;
  logic [SAMPLE_BITS-1:0] nb1, nb2, nb3;
  logic [WEIGHT_W-1:0]    sw1, sw2, wt3, wt4;
  logic [WEIGHT_W+SAMPLE_BITS-1:0] prod4;
  logic [NUM_W-1:0]       num;
  logic [DEN_W-1:0]       den;
  logic [15:0]            quot;
  logic                   res_valid;
  result_t                res;

  logic                   pop;
  logic                   inb;
  logic                   last_pos;
  logic [SAMPLE_BITS-1:0] diff;
  logic [7:0]             rg_raddr;
  logic [WEIGHT_W-1:0]    rg_rdata;
  logic [WEIGHT_W-1:0]    sp_rdata;
  logic [2*WEIGHT_W-1:0]  wprod;
  logic                   rg_we;
  logic                   sp_we;
  logic                   div_busy;
  logic                   div_done;
  logic [NUM_W-1:0]       div_q;
  logic                   res_load;
  logic [RA_W-1:0]        row_next;
  logic [RA_W-1:0]        plane_next;
  logic signed [X_W-1:0]  col_lo, row_lo;
  logic signed [Z_W-1:0]  slice_lo;

  assign job_ready  = (state == S_IDLE);
  assign pop        = job_valid && job_ready;
  assign idle       = (state == S_IDLE);
  assign rg_we      = pop && (job.kind == JOB_RANGE) && !job.table_index[TIDX_W-1];
  assign sp_we      = pop && (job.kind == JOB_SPATIAL) &&
                      (job.table_index < TIDX_W'(SPATIAL_N));
  assign ring_raddr = (state == S_SCAN) ? addr : ca;
  assign rg_raddr   = (|p1[P_W-1:24]) ? 8'hFF : p1[23:16];
  assign diff       = (ring_rdata > center) ? ring_rdata - center : center - ring_rdata;
  assign wprod      = rg_rdata * sw2;
  assign res_load   = (state == S_OUT) && (!res_valid || result_ready);
  assign row_next   = wrap_add(row_base, RA_W'(geom.w));
  assign plane_next = wrap_add(plane_base, RA_W'(geom.wh));
  assign col_lo     = $signed({2'b00, cur.col}) - X_W'(RADIUS);
  assign row_lo     = $signed({2'b00, cur.row}) - X_W'(RADIUS);
  assign slice_lo   = $signed({2'b00, cur.slice}) - Z_W'(RADIUS);
  assign inb        = (nx >= 0) && (nx < $signed({1'b0, geom.w})) &&
                      (ny >= 0) && (ny < $signed({1'b0, geom.h})) &&
                      (nz >= 0) && (nz < $signed({1'b0, geom.d}));
  assign last_pos   = (dx == DC_W'(DIAM - 1)) && (dy == DC_W'(DIAM - 1)) &&
                      (dz == DC_W'(DIAM - 1));

  assign result_valid = res_valid;
  assign result       = res;

  vbf_ram #(.WIDTH(WEIGHT_W), .DEPTH(RANGE_N)) u_range (
    .clk  (clk),
    .we   (rg_we),
    .waddr(job.table_index[7:0]),
    .wdata(job.weight),
    .raddr(rg_raddr),
    .rdata(rg_rdata)
  );

  vbf_ram #(.WIDTH(WEIGHT_W), .DEPTH(SPATIAL_N)) u_spatial (
    .clk  (clk),
    .we   (sp_we),
    .waddr(job.table_index[SP_AW-1:0]),
    .wdata(job.weight),
    .raddr(pos),
    .rdata(sp_rdata)
  );

  vbf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_DIV),
    .dividend(num),
    .divisor (den),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ca        <= '0;
      res_valid <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN) && inb;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result_ready) begin
        res_valid <= 1'b0;
      end
      if (restart) begin
        ca <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && job.kind == JOB_FILTER) begin
            state <= S_CWAIT;
          end
        end
        S_CWAIT: state <= S_SCAN;
        S_SCAN: begin
          if (last_pos) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!(v1 || v2 || v3 || v4 || v5)) begin
            state <= S_DIV;
          end
        end
        S_DIV:   state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            state <= S_IDLE;
            ca    <= cur.done ? '0 : wrap_add(ca, RA_W'(1));
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end
    if (state == S_CWAIT) begin
      center     <= ring_rdata;
      addr       <= wrap_add(ca, RA_W'(RING_N) - RA_W'(geom.lag));
      row_base   <= wrap_add(ca, RA_W'(RING_N) - RA_W'(geom.lag));
      plane_base <= wrap_add(ca, RA_W'(RING_N) - RA_W'(geom.lag));
      pos        <= '0;
      dx         <= '0;
      dy         <= '0;
      dz         <= '0;
      nx         <= col_lo;
      ny         <= row_lo;
      nz         <= slice_lo;
      num        <= '0;
      den        <= '0;
    end
    if (state == S_SCAN) begin
      pos <= pos + SP_AW'(1);
      if (dx != DC_W'(DIAM - 1)) begin
        dx   <= dx + DC_W'(1);
        nx   <= nx + X_W'(1);
        addr <= wrap_add(addr, RA_W'(1));
      end else begin
        dx <= '0;
        nx <= col_lo;
        if (dy != DC_W'(DIAM - 1)) begin
          dy       <= dy + DC_W'(1);
          ny       <= ny + X_W'(1);
          row_base <= row_next;
          addr     <= row_next;
        end else begin
          dy         <= '0;
          ny         <= row_lo;
          dz         <= dz + DC_W'(1);
          nz         <= nz + Z_W'(1);
          plane_base <= plane_next;
          row_base   <= plane_next;
          addr       <= plane_next;
        end
      end
    end
    p1    <= diff * geom.scale;
    nb1   <= ring_rdata;
    sw1   <= sp_rdata;
    nb2   <= nb1;
    sw2   <= sw1;
    wt3   <= wprod[2*WEIGHT_W-1:WEIGHT_W];
    nb3   <= nb2;
    prod4 <= wt3 * nb3;
    wt4   <= wt3;
    if (v5) begin
      num <= num + NUM_W'(prod4);
      den <= den + DEN_W'(wt4);
    end
    if (div_done) begin
      quot <= (den == '0) ? 16'd0 : div_q[15:0];
    end
    if (res_load) begin
      res.filtered    <= quot;
      res.out_column  <= cur.col[7:0];
      res.out_row     <= cur.row[7:0];
      res.out_slice   <= cur.slice;
      res.volume_done <= cur.done;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !v5)
    else $error("neighbour pipeline active while idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !(v1 || v2 || v3 || v4 || v5) && !div_busy)
    else $error("division started before accumulation finished");

endmodule

>>> rtl/core/volume_bilateral_filter_unit.sv
// Volume bilateral filter: takes voxel samples in raster order (column, row, slice), keeps
// 2*RADIUS+1 slices in a ring memory and emits each voxel's bilateral-filtered value once its
// whole neighbourhood has arrived, i.e. after RADIUS*(W*H+W+1) further samples; padding items
// flush the tail. Weight tables must be loaded through load items before use. In the back end
// each voxel's neighbours are issued one per cycle through a single shared ring/weight/multiply
// pipeline, then a divider (NUM_W = 39 at radius 2 with 16-bit samples) yields one quotient
// bit per cycle. After a register write the block takes no item until its settle counter has
// run down; after the last voxel of a volume it waits for the back end to empty. Depends on
// vbf_pkg and all vbf_* modules.
module volume_bilateral_filter_unit import vbf_pkg::*; #(
  parameter int RADIUS      = RADIUS_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  localparam int RING_N = (2*RADIUS+1) * MAX_WIDTH * MAX_HEIGHT;
  localparam int RA_W   = $clog2(RING_N);

  logic [8:0]         vol_width;
  logic [8:0]         vol_height;
  logic [12:0]        vol_depth;
  logic [SCALE_W-1:0] diff_scale;
  logic [1:0]         settle;
  logic               cfg_hit;
  logic               restart;
  logic [DIM_W-1:0]   w_c;
  logic [DIM_W-1:0]   h_c;
  logic [DEPTH_W-1:0] d_c;
  logic [AREA_W-1:0]  wh;
  logic [LAG_W-1:0]   lag;
  geom_t              geom;

  logic               job_valid;
  logic               job_ready;
  job_t               job;
  logic               q_valid;
  logic               q_ready;
  job_t               q_job;
  logic               ring_we;
  logic [RA_W-1:0]    ring_waddr;
  logic [SAMPLE_BITS-1:0] ring_wdata;
  logic [RA_W-1:0]    ring_raddr;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic               back_idle;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index) inside
      REG_VOL_WIDTH, REG_VOL_HEIGHT, REG_VOL_DEPTH, REG_DIFF_SCALE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign restart = cfg_valid && cfg_ready && cfg_hit;

  assign w_c = (vol_width == '0) ? DIM_W'(1) :
               (DIM_W'(vol_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(vol_width);
  assign h_c = (vol_height == '0) ? DIM_W'(1) :
               (DIM_W'(vol_height) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
               DIM_W'(vol_height);
  assign d_c = (vol_depth == '0) ? DEPTH_W'(1) :
               (vol_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : vol_depth;

  always_comb begin
    geom.w     = w_c;
    geom.h     = h_c;
    geom.d     = d_c;
    geom.wh    = wh;
    geom.lag   = lag;
    geom.scale = diff_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_width  <= 9'd256;
      vol_height <= 9'd256;
      vol_depth  <= 13'd256;
      diff_scale <= 24'd65536;
      settle     <= 2'd2;
    end else if (restart) begin
      settle <= 2'd2;
      unique case (cfg_index)
        REG_VOL_WIDTH:  vol_width  <= cfg_data[8:0];
        REG_VOL_HEIGHT: vol_height <= cfg_data[8:0];
        REG_VOL_DEPTH:  vol_depth  <= cfg_data[12:0];
        REG_DIFF_SCALE: diff_scale <= cfg_data;
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    wh  <= AREA_W'(w_c) * AREA_W'(h_c);
    lag <= LAG_W'(RADIUS) * LAG_W'(wh) + LAG_W'(RADIUS) * LAG_W'(w_c) + LAG_W'(RADIUS);
  end

  vbf_front #(
    .RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .geom_ok    (settle == 2'd0),
    .geom       (geom),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .back_idle  (back_idle),
    .queue_empty(!q_valid)
  );

  vbf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_N)) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  vbf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(job_valid),
    .push_ready(job_ready),
    .push_data (job),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_job)
  );

  vbf_back #(
    .RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .geom        (geom),
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job         (q_job),
    .ring_raddr  (ring_raddr),
    .ring_rdata  (ring_rdata),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .idle        (back_idle)
  );

endmodule
